### hdl/modulated_delay_tap_filter_defines.svh
// ---------------------------------------------------------------------------
// Modulated delay tap filter assertion macros
// Shared property forms for the concurrent checks of the filter.
// ---------------------------------------------------------------------------
`ifndef MODULATED_DELAY_TAP_FILTER_DEFINES_SVH
`define MODULATED_DELAY_TAP_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MDTF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MDTF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/mdtf_pkg.sv
// ---------------------------------------------------------------------------
// Modulated delay tap filter package
// Field widths, codes and the command and status bundles between the
// controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package mdtf_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int LFO_W      = 16;
	localparam int COEF_W     = 16;
	localparam int SLOT_W     = 5;
	localparam int DELAY_W    = 12;
	localparam int PCOUNT_W   = 4;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int STRIDE_W   = 13;
	localparam int MUL_W      = 18;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int ACC_W      = 33;
	localparam int ACC_SHIFT  = 14;
	localparam int FRAC_W     = 16;
	localparam int TAP_W      = 2;

	localparam int SAMPLE_MAX = 32767;
	localparam int SAMPLE_MIN = -32768;

	localparam logic FUNC_PROCESS = 1'b0;
	localparam logic FUNC_COEF    = 1'b1;

	localparam logic [TAP_W-1:0] TAP_C0 = 2'd0;
	localparam logic [TAP_W-1:0] TAP_C1 = 2'd1;
	localparam logic [TAP_W-1:0] TAP_C2 = 2'd2;

	typedef enum logic [MODE_W-1:0] {
		MODE_FF,
		MODE_FB,
		MODE_MIX,
		MODE_BYPASS
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE,
		CFG_BASE,
		CFG_DEV,
		CFG_PCOUNT
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MUL_P,
		MUL_STRIDE,
		MUL_INTERP,
		MUL_MAC
	} mul_sel_t;

	typedef struct packed {
		logic             clr_wr;
		logic             load;
		logic             coef_wr;
		logic             mul_en;
		mul_sel_t         mul_sel;
		logic [TAP_W-1:0] tap;
		logic             cap_len;
		logic             cap_kf;
		logic             cap_stride;
		logic             coef_rd_lo;
		logic             coef_rd_hi;
		logic             cap_lo;
		logic             cap_coef;
		logic             div_start;
		logic             div_sel_stride;
		logic             div_step;
		logic             cap_pos;
		logic             cap_idx1;
		logic             cap_idx2;
		logic             ring_wr_x;
		logic             ring_wr_y;
		logic             ring_rd1;
		logic             ring_rd2;
		logic             cap_r1;
		logic             cap_r2;
		logic             acc_en;
		logic             acc_first;
		logic             acc_sub;
		logic             sat_en;
		logic             adv_pos;
		logic             out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic  func;
		mode_t mode;
		logic  clr_last;
		logic  div_last;
	} dp_stat_t;

endpackage

`default_nettype wire

### hdl/mdtf_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module mdtf_ram #(
	parameter int WIDTH  = 16,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output      logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### hdl/mdtf_datapath.sv
// ---------------------------------------------------------------------------
// Modulated delay tap filter datapath
// Configuration registers, item registers, the shared multiplier, the
// bit-serial remainder unit, coefficient table, delay ring and accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

module mdtf_datapath
	import mdtf_pkg::*;
#(
	parameter int DELAY_DEPTH = 4096,
	parameter int MAX_POINTS  = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr,
	input  wire logic [CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [CFG_DATA_W-1:0]       cfg_data,
	input  wire logic                        func,
	input  wire logic signed [SAMPLE_W-1:0]  sample_in,
	input  wire logic signed [SAMPLE_W-1:0]  dry_in,
	input  wire logic [LFO_W-1:0]            lfo_value,
	input  wire logic [SLOT_W-1:0]           coef_slot,
	input  wire logic signed [COEF_W-1:0]    coef_word,
	input  wire dp_cmd_t                     cmd,
	output      dp_stat_t                    stat,
	output      logic signed [SAMPLE_W-1:0]  sample_out
);

	localparam int AW       = $clog2(DELAY_DEPTH);
	localparam int LEN_W    = (AW + 1 > STRIDE_W) ? AW + 1 : STRIDE_W;
	localparam int DW       = (AW > STRIDE_W) ? AW : STRIDE_W;
	localparam int DCW      = $clog2(DW + 1);
	localparam int TW       = MAX_POINTS * 3;
	localparam int TAW      = $clog2(TW);
	localparam int TA_EXT_W = TAW + 1;
	localparam int PW       = $clog2(MAX_POINTS + 1);
	localparam int KW       = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int KX_W     = PW + 1;
	localparam int SH_W     = ACC_W - ACC_SHIFT;

	mode_t                 mode_q;
	logic [DELAY_W-1:0]    base_q;
	logic [DELAY_W-1:0]    dev_q;
	logic [PCOUNT_W-1:0]   pcount_q;

	logic                        func_q;
	logic signed [SAMPLE_W-1:0]  x_q;
	logic signed [SAMPLE_W-1:0]  dry_q;
	logic [LFO_W-1:0]            lfo_q;
	logic [SLOT_W-1:0]           slot_q;
	logic signed [COEF_W-1:0]    word_q;

	logic [PW-1:0]         pts;
	logic [LEN_W-1:0]      len_sum;
	logic [LEN_W-1:0]      len_next;
	logic [LEN_W-1:0]      len_q;

	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod_q;

	logic [KW-1:0]         k_q;
	logic [FRAC_W-1:0]     f_q;
	logic                  interp;
	logic [STRIDE_W-1:0]   stride_q;

	logic [TA_EXT_W-1:0]   lo_ext;
	logic [TA_EXT_W-1:0]   hi_ext;
	logic                  coef_we;
	logic [COEF_W-1:0]     coef_rd_data;
	logic signed [COEF_W-1:0] lo_q;
	logic signed [COEF_W:0]   diff;
	logic signed [COEF_W-1:0] c0_q;
	logic signed [COEF_W-1:0] c1_q;
	logic signed [COEF_W-1:0] c2_q;
	logic signed [COEF_W-1:0] c_new;
	logic signed [COEF_W-1:0] c_sel;

	logic [DW-1:0]         div_sh_q;
	logic [LEN_W-1:0]      rem_q;
	logic [DCW-1:0]        div_cnt_q;
	logic [LEN_W:0]        trial;

	logic [AW-1:0]         ring_pos_q;
	logic [AW-1:0]         pos_q;
	logic [AW-1:0]         clr_addr_q;
	logic [LEN_W:0]        twice;
	logic [LEN_W-1:0]      d2;
	logic [LEN_W-1:0]      d2_q;
	logic [LEN_W-1:0]      pos_ext;
	logic [LEN_W-1:0]      i1;
	logic [LEN_W-1:0]      i2;
	logic [AW-1:0]         i1_q;
	logic [AW-1:0]         i2_q;
	logic [LEN_W-1:0]      pos_inc;

	logic                  ring_we;
	logic [AW-1:0]         ring_wr_addr;
	logic [SAMPLE_W-1:0]   ring_wr_data;
	logic [SAMPLE_W-1:0]   ring_rd_data;
	logic signed [SAMPLE_W-1:0] r1_q;
	logic signed [SAMPLE_W-1:0] r2_q;

	logic signed [SAMPLE_W-1:0] mac_x;
	logic signed [ACC_W-1:0]    acc_base;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [SH_W-1:0]     acc_sh;
	logic signed [SAMPLE_W-1:0] y_sat;
	logic signed [SAMPLE_W-1:0] y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_BYPASS;
			base_q     <= DELAY_W'(1);
			dev_q      <= '0;
			pcount_q   <= PCOUNT_W'(1);
			ring_pos_q <= '0;
			clr_addr_q <= '0;
			div_cnt_q  <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_MODE:   mode_q   <= mode_t'(cfg_data[MODE_W-1:0]);
					CFG_BASE:   base_q   <= cfg_data[DELAY_W-1:0];
					CFG_DEV:    dev_q    <= cfg_data[DELAY_W-1:0];
					CFG_PCOUNT: pcount_q <= cfg_data[PCOUNT_W-1:0];
					default:    ;
				endcase
			end
			if (cmd.clr_wr) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (cmd.div_start) begin
				div_cnt_q <= DCW'(DW);
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q - DCW'(1);
			end
			if (cmd.adv_pos) begin
				ring_pos_q <= (pos_inc == len_q) ? '0 : AW'(pos_inc);
			end
		end
	end

	always_comb begin
		if (pcount_q == '0) begin
			pts = PW'(1);
		end else if (32'(pcount_q) > MAX_POINTS) begin
			pts = PW'(MAX_POINTS);
		end else begin
			pts = PW'(pcount_q);
		end
	end

	assign len_sum  = LEN_W'(base_q) + LEN_W'(dev_q) + LEN_W'(1);
	assign len_next = (len_sum > LEN_W'(DELAY_DEPTH)) ? LEN_W'(DELAY_DEPTH) : len_sum;

	always_comb begin
		mac_x = x_q;
		c_sel = c0_q;
		case (cmd.tap)
			TAP_C0: begin
				mac_x = (mode_q == MODE_MIX) ? dry_q : x_q;
				c_sel = c0_q;
			end
			TAP_C1: begin
				mac_x = (mode_q == MODE_MIX) ? x_q : r1_q;
				c_sel = c1_q;
			end
			default: begin
				mac_x = r2_q;
				c_sel = c2_q;
			end
		endcase
	end

	assign diff = {coef_rd_data[COEF_W-1], coef_rd_data} - {lo_q[COEF_W-1], lo_q};

	always_comb begin
		case (cmd.mul_sel)
			MUL_P: begin
				mul_a = $signed(MUL_W'(lfo_q));
				mul_b = $signed(MUL_W'(pts - PW'(1)));
			end
			MUL_STRIDE: begin
				mul_a = $signed(MUL_W'(lfo_q));
				mul_b = $signed(MUL_W'(dev_q));
			end
			MUL_INTERP: begin
				mul_a = $signed(MUL_W'(f_q));
				mul_b = MUL_W'(diff);
			end
			default: begin
				mul_a = MUL_W'(mac_x);
				mul_b = MUL_W'(c_sel);
			end
		endcase
	end

	assign interp = (f_q != '0) && ((KX_W'(k_q) + KX_W'(1)) < KX_W'(pts));
	assign lo_ext = TA_EXT_W'(k_q) + TA_EXT_W'(k_q) + TA_EXT_W'(k_q) + TA_EXT_W'(cmd.tap);
	assign hi_ext = interp ? lo_ext + TA_EXT_W'(3) : lo_ext;
	assign coef_we = cmd.coef_wr && (32'(slot_q) < TW);
	assign c_new = interp ? lo_q + prod_q[FRAC_W +: COEF_W] : lo_q;

	assign trial = {rem_q, div_sh_q[DW-1]};

	assign twice   = {rem_q, 1'b0};
	assign d2      = (twice >= {1'b0, len_q}) ? LEN_W'(twice - {1'b0, len_q}) : LEN_W'(twice);
	assign pos_ext = LEN_W'(pos_q);
	assign i1      = (pos_ext >= rem_q) ? pos_ext - rem_q : pos_ext + len_q - rem_q;
	assign i2      = (pos_ext >= d2_q) ? pos_ext - d2_q : pos_ext + len_q - d2_q;
	assign pos_inc = pos_ext + LEN_W'(1);

	always_comb begin
		ring_we      = cmd.clr_wr || cmd.ring_wr_x || cmd.ring_wr_y;
		ring_wr_addr = pos_q;
		ring_wr_data = y_q;
		if (cmd.clr_wr) begin
			ring_wr_addr = clr_addr_q;
			ring_wr_data = '0;
		end else if (cmd.ring_wr_x) begin
			ring_wr_data = x_q;
		end
	end

	assign acc_base = cmd.acc_first ? '0 : acc_q;
	assign acc_sh   = acc_q[ACC_W-1:ACC_SHIFT];

	always_comb begin
		if (acc_sh > SH_W'(SAMPLE_MAX)) begin
			y_sat = SAMPLE_W'(SAMPLE_MAX);
		end else if (acc_sh < SH_W'(SAMPLE_MIN)) begin
			y_sat = SAMPLE_W'(SAMPLE_MIN);
		end else begin
			y_sat = SAMPLE_W'(acc_sh);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			x_q    <= sample_in;
			dry_q  <= dry_in;
			lfo_q  <= lfo_value;
			slot_q <= coef_slot;
			word_q <= coef_word;
		end
		if (cmd.cap_len) begin
			len_q <= len_next;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.cap_kf) begin
			k_q <= prod_q[FRAC_W +: KW];
			f_q <= prod_q[FRAC_W-1:0];
		end
		if (cmd.cap_stride) begin
			stride_q <= STRIDE_W'(base_q) + STRIDE_W'(prod_q[FRAC_W +: DELAY_W]);
		end
		if (cmd.cap_lo) begin
			lo_q <= coef_rd_data;
		end
		if (cmd.cap_coef) begin
			case (cmd.tap)
				TAP_C0:  c0_q <= c_new;
				TAP_C1:  c1_q <= c_new;
				default: c2_q <= c_new;
			endcase
		end
		if (cmd.div_start) begin
			div_sh_q <= cmd.div_sel_stride ? DW'(stride_q) : DW'(ring_pos_q);
			rem_q    <= '0;
		end else if (cmd.div_step) begin
			div_sh_q <= {div_sh_q[DW-2:0], 1'b0};
			rem_q    <= (trial >= {1'b0, len_q}) ? LEN_W'(trial - {1'b0, len_q})
			                                     : LEN_W'(trial);
		end
		if (cmd.cap_pos) begin
			pos_q <= AW'(rem_q);
		end
		if (cmd.cap_idx1) begin
			d2_q <= d2;
			i1_q <= AW'(i1);
		end
		if (cmd.cap_idx2) begin
			i2_q <= AW'(i2);
		end
		if (cmd.cap_r1) begin
			r1_q <= ring_rd_data;
		end
		if (cmd.cap_r2) begin
			r2_q <= ring_rd_data;
		end
		if (cmd.acc_en) begin
			acc_q <= cmd.acc_sub ? acc_base - ACC_W'(prod_q) : acc_base + ACC_W'(prod_q);
		end
		if (cmd.sat_en) begin
			y_q <= y_sat;
		end
		if (cmd.out_load) begin
			sample_out <= (mode_q == MODE_BYPASS) ? dry_q : y_q;
		end
	end

	mdtf_ram #(
		.WIDTH  (COEF_W),
		.DEPTH  (TW),
		.ADDR_W (TAW)
	) u_coef_ram (
		.clk     (clk),
		.wr_en   (coef_we),
		.wr_addr (TAW'(slot_q)),
		.wr_data (word_q),
		.rd_en   (cmd.coef_rd_lo || cmd.coef_rd_hi),
		.rd_addr (cmd.coef_rd_hi ? hi_ext[TAW-1:0] : lo_ext[TAW-1:0]),
		.rd_data (coef_rd_data)
	);

	mdtf_ram #(
		.WIDTH  (SAMPLE_W),
		.DEPTH  (DELAY_DEPTH),
		.ADDR_W (AW)
	) u_ring_ram (
		.clk     (clk),
		.wr_en   (ring_we),
		.wr_addr (ring_wr_addr),
		.wr_data (ring_wr_data),
		.rd_en   (cmd.ring_rd1 || cmd.ring_rd2),
		.rd_addr (cmd.ring_rd2 ? i2_q : i1_q),
		.rd_data (ring_rd_data)
	);

	assign stat.func     = func_q;
	assign stat.mode     = mode_q;
	assign stat.clr_last = (clr_addr_q == AW'(DELAY_DEPTH - 1));
	assign stat.div_last = (div_cnt_q == DCW'(1));

endmodule

`default_nettype wire

### hdl/mdtf_ctrl.sv
// ---------------------------------------------------------------------------
// Modulated delay tap filter controller
// Sequences the ring clear, coefficient interpolation, remainder passes,
// ring accesses and the multiply-accumulate; owns both handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

module mdtf_ctrl
	import mdtf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output      logic     in_stall,
	output      logic     out_valid,
	input  wire logic     out_stall,
	input  wire dp_stat_t stat,
	output      dp_cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_KF,
		ST_STRIDE,
		ST_C_LO,
		ST_C_HI,
		ST_C_MUL,
		ST_C_ACC,
		ST_DPOS_INIT,
		ST_DPOS_RUN,
		ST_DSTR_INIT,
		ST_DSTR_RUN,
		ST_IDX1,
		ST_IDX2,
		ST_WR_X,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_MAC0,
		ST_MAC1,
		ST_MAC2,
		ST_MAC3,
		ST_SAT,
		ST_WR_Y,
		ST_OUT
	} state_t;

	state_t           state_q;
	logic [TAP_W-1:0] tap_q;
	logic             out_free;

	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			tap_q     <= TAP_C0;
			out_valid <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (stat.clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					if (stat.func == FUNC_COEF) begin
						state_q <= ST_IDLE;
					end else if (stat.mode == MODE_BYPASS) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_KF;
					end
				end
				ST_KF:     state_q <= ST_STRIDE;
				ST_STRIDE: begin
					tap_q   <= TAP_C0;
					state_q <= ST_C_LO;
				end
				ST_C_LO:   state_q <= ST_C_HI;
				ST_C_HI:   state_q <= ST_C_MUL;
				ST_C_MUL:  state_q <= ST_C_ACC;
				ST_C_ACC: begin
					if (tap_q == TAP_C2) begin
						state_q <= (stat.mode == MODE_MIX) ? ST_MAC0 : ST_DPOS_INIT;
					end else begin
						tap_q   <= tap_q + TAP_W'(1);
						state_q <= ST_C_LO;
					end
				end
				ST_DPOS_INIT: state_q <= ST_DPOS_RUN;
				ST_DPOS_RUN: begin
					if (stat.div_last) begin
						state_q <= ST_DSTR_INIT;
					end
				end
				ST_DSTR_INIT: state_q <= ST_DSTR_RUN;
				ST_DSTR_RUN: begin
					if (stat.div_last) begin
						state_q <= ST_IDX1;
					end
				end
				ST_IDX1: state_q <= ST_IDX2;
				ST_IDX2: state_q <= (stat.mode == MODE_FF) ? ST_WR_X : ST_RD1;
				ST_WR_X: state_q <= ST_RD1;
				ST_RD1:  state_q <= ST_RD2;
				ST_RD2:  state_q <= ST_RD3;
				ST_RD3:  state_q <= ST_MAC0;
				ST_MAC0: state_q <= ST_MAC1;
				ST_MAC1: state_q <= ST_MAC2;
				ST_MAC2: state_q <= (stat.mode == MODE_MIX) ? ST_SAT : ST_MAC3;
				ST_MAC3: state_q <= ST_SAT;
				ST_SAT:  state_q <= (stat.mode == MODE_FB) ? ST_WR_Y : ST_OUT;
				ST_WR_Y: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd     = '0;
		cmd.tap = tap_q;
		unique case (state_q)
			ST_CLEAR: cmd.clr_wr = 1'b1;
			ST_IDLE:  cmd.load   = in_valid;
			ST_DISPATCH: begin
				cmd.coef_wr = (stat.func == FUNC_COEF);
				cmd.mul_en  = (stat.func != FUNC_COEF);
				cmd.mul_sel = MUL_P;
				cmd.cap_len = 1'b1;
			end
			ST_KF: begin
				cmd.cap_kf  = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_STRIDE;
			end
			ST_STRIDE: cmd.cap_stride = 1'b1;
			ST_C_LO:   cmd.coef_rd_lo = 1'b1;
			ST_C_HI: begin
				cmd.cap_lo     = 1'b1;
				cmd.coef_rd_hi = 1'b1;
			end
			ST_C_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_INTERP;
			end
			ST_C_ACC:     cmd.cap_coef = 1'b1;
			ST_DPOS_INIT: cmd.div_start = 1'b1;
			ST_DPOS_RUN:  cmd.div_step = 1'b1;
			ST_DSTR_INIT: begin
				cmd.cap_pos        = 1'b1;
				cmd.div_start      = 1'b1;
				cmd.div_sel_stride = 1'b1;
			end
			ST_DSTR_RUN: cmd.div_step = 1'b1;
			ST_IDX1:     cmd.cap_idx1 = 1'b1;
			ST_IDX2:     cmd.cap_idx2 = 1'b1;
			ST_WR_X:     cmd.ring_wr_x = 1'b1;
			ST_RD1:      cmd.ring_rd1 = 1'b1;
			ST_RD2: begin
				cmd.cap_r1   = 1'b1;
				cmd.ring_rd2 = 1'b1;
			end
			ST_RD3: cmd.cap_r2 = 1'b1;
			ST_MAC0: begin
				cmd.tap     = TAP_C0;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_MAC;
			end
			ST_MAC1: begin
				cmd.tap       = TAP_C1;
				cmd.mul_en    = 1'b1;
				cmd.mul_sel   = MUL_MAC;
				cmd.acc_en    = 1'b1;
				cmd.acc_first = 1'b1;
			end
			ST_MAC2: begin
				cmd.tap     = TAP_C2;
				cmd.mul_en  = (stat.mode != MODE_MIX);
				cmd.mul_sel = MUL_MAC;
				cmd.acc_en  = 1'b1;
				cmd.acc_sub = (stat.mode == MODE_FB);
			end
			ST_MAC3: begin
				cmd.acc_en  = 1'b1;
				cmd.acc_sub = (stat.mode == MODE_FB);
			end
			ST_SAT: begin
				cmd.sat_en  = 1'b1;
				cmd.adv_pos = (stat.mode == MODE_FF);
			end
			ST_WR_Y: begin
				cmd.ring_wr_y = 1'b1;
				cmd.adv_pos   = 1'b1;
			end
			ST_OUT:  cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

### hdl/modulated_delay_tap_filter.sv
// ---------------------------------------------------------------------------
// Modulated delay tap filter
// Two-tap comb filter with an LFO-modulated tap delay and a coefficient
// triple interpolated from a small table. After reset the delay ring is
// swept to zero, one entry per cycle, over all DELAY_DEPTH entries; input
// stays stalled during the sweep while configuration writes are taken at
// once. One item is worked at a time and the next is taken while a
// finished result waits in the output register. Mix time is set by the
// three interpolation passes through the single read port of the
// coefficient table and the shared multiplier. Feedforward and feedback
// time is set by the two bit-serial remainder passes that fold the write
// position and the tap delay into the ring length.
// ---------------------------------------------------------------------------
`default_nettype none
`include "modulated_delay_tap_filter_defines.svh"

module modulated_delay_tap_filter
	import mdtf_pkg::*;
#(
	parameter int DELAY_DEPTH = 4096,
	parameter int MAX_POINTS  = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output      logic                       in_stall,
	input  wire logic                       func,
	input  wire logic signed [SAMPLE_W-1:0] sample_in,
	input  wire logic signed [SAMPLE_W-1:0] dry_in,
	input  wire logic [LFO_W-1:0]           lfo_value,
	input  wire logic [SLOT_W-1:0]          coef_slot,
	input  wire logic signed [COEF_W-1:0]   coef_word,
	output      logic                       out_valid,
	input  wire logic                       out_stall,
	output      logic signed [SAMPLE_W-1:0] sample_out,
	input  wire logic                       cfg_valid,
	output      logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [CFG_DATA_W-1:0]      cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	mdtf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	mdtf_datapath #(
		.DELAY_DEPTH (DELAY_DEPTH),
		.MAX_POINTS  (MAX_POINTS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.func       (func),
		.sample_in  (sample_in),
		.dry_in     (dry_in),
		.lfo_value  (lfo_value),
		.coef_slot  (coef_slot),
		.coef_word  (coef_word),
		.cmd        (cmd),
		.stat       (stat),
		.sample_out (sample_out)
	);

	`MDTF_ASSERT_NOW(a_no_result_overwrite, cmd.out_load, !(out_valid && out_stall), "result overwritten before taken")
	`MDTF_ASSERT_NOW(a_clear_blocks_input, cmd.clr_wr, in_stall, "request accepted during ring clear")
	`MDTF_ASSERT_NEXT(a_feedback_store, cmd.sat_en && (stat.mode == MODE_FB), cmd.ring_wr_y, "feedback result not stored")

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Modulated delay tap filter testbench
// Loads the coefficient table, then drives short directed runs through each
// filter mode and the ring and point-count corner cases, followed by random
// request traffic under several settings and pacing patterns. Every result
// is checked against a cycle-free model of the filter kept in this file.
// ---------------------------------------------------------------------------

module testbench
	import mdtf_pkg::*;
();

	localparam int RING_DEPTH   = 4096;
	localparam int POINTS_MAX   = 8;
	localparam int TABLE_WORDS  = POINTS_MAX * 3;
	localparam int DRAIN_CYCLES = 80;
	localparam int SEGMENTS     = 12;
	localparam int SEG_REQUESTS = 150;

	typedef struct packed {
		logic                       func;
		logic signed [SAMPLE_W-1:0] sample;
		logic signed [SAMPLE_W-1:0] dry;
		logic [LFO_W-1:0]           lfo;
		logic [SLOT_W-1:0]          slot;
		logic signed [COEF_W-1:0]   word;
	} filter_req_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic                       func;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic signed [SAMPLE_W-1:0] dry_in;
	logic [LFO_W-1:0]           lfo_value;
	logic [SLOT_W-1:0]          coef_slot;
	logic signed [COEF_W-1:0]   coef_word;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;

	mode_t                      cur_mode;
	logic [DELAY_W-1:0]         cur_base;
	logic [DELAY_W-1:0]         cur_dev;
	logic [PCOUNT_W-1:0]        cur_points;
	logic [DELAY_W-1:0]         write_pos;
	logic signed [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
	logic signed [COEF_W-1:0]   coef_mem [TABLE_WORDS];

	logic signed [SAMPLE_W-1:0] expected_samples [$];

	int send_idle_pct;
	int stall_pct;
	int requests_sent;
	int coef_writes_sent;
	int samples_checked;
	int settings_count;
	int error_count;

	modulated_delay_tap_filter #(
		.DELAY_DEPTH(RING_DEPTH),
		.MAX_POINTS (POINTS_MAX)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.sample_in (sample_in),
		.dry_in    (dry_in),
		.lfo_value (lfo_value),
		.coef_slot (coef_slot),
		.coef_word (coef_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sample_out(sample_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic logic signed [SAMPLE_W-1:0] scale_to_sample(input longint acc);
		longint s;
		s = acc >>> ACC_SHIFT;
		if (s > SAMPLE_MAX)
			s = SAMPLE_MAX;
		else if (s < SAMPLE_MIN)
			s = SAMPLE_MIN;
		return s[SAMPLE_W-1:0];
	endfunction

	// advance the filter state by one request, queue the sample it yields
	task automatic apply_request(input filter_req_t r);
		int unsigned stride, pts, p, k, f, len, pos, d, d2, i1, i2;
		longint      coef_now [3];
		longint      lo, hi, acc;
		logic signed [SAMPLE_W-1:0] y;
		if (r.func == FUNC_COEF) begin
			if (r.slot < TABLE_WORDS)
				coef_mem[r.slot] = r.word;
			return;
		end
		stride = cur_base + ((32'(cur_dev) * 32'(r.lfo)) >> 16);
		pts = cur_points;
		if (pts == 0)
			pts = 1;
		if (pts > POINTS_MAX)
			pts = POINTS_MAX;
		p = 32'(r.lfo) * (pts - 1);
		k = p >> 16;
		f = p & 32'hFFFF;
		if (k >= pts)
			k = pts - 1;
		for (int t = 0; t < 3; t++) begin
			lo = coef_mem[k * 3 + t];
			coef_now[t] = lo;
			if (f > 0 && k + 1 < pts) begin
				hi = coef_mem[(k + 1) * 3 + t];
				coef_now[t] = lo + ((longint'(f) * (hi - lo)) >>> 16);
			end
		end
		case (cur_mode)
			MODE_MIX: begin
				acc = longint'(r.dry) * coef_now[0] + longint'(r.sample) * coef_now[1];
				y = scale_to_sample(acc);
			end
			MODE_BYPASS: begin
				y = r.dry;
			end
			default: begin
				len = cur_base + cur_dev + 1;
				if (len > RING_DEPTH)
					len = RING_DEPTH;
				pos = write_pos % len;
				d = stride % len;
				d2 = (2 * d) % len;
				i1 = (pos + len - d) % len;
				i2 = (pos + len - d2) % len;
				if (cur_mode == MODE_FF) begin
					ring_mem[pos] = r.sample;
					acc = longint'(r.sample) * coef_now[0]
						+ longint'(ring_mem[i1]) * coef_now[1]
						+ longint'(ring_mem[i2]) * coef_now[2];
					y = scale_to_sample(acc);
				end else begin
					acc = longint'(r.sample) * coef_now[0]
						- longint'(ring_mem[i1]) * coef_now[1]
						- longint'(ring_mem[i2]) * coef_now[2];
					y = scale_to_sample(acc);
					ring_mem[pos] = y;
				end
				write_pos = DELAY_W'((pos + 1) % len);
			end
		endcase
		expected_samples.push_back(y);
	endtask

	always @(posedge clk) begin : check_samples
		logic signed [SAMPLE_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_samples.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected sample_out %0d at %0t", sample_out, $realtime);
			end else begin
				want = expected_samples.pop_front();
				samples_checked++;
				if (sample_out !== want) begin
					error_count++;
					if (error_count <= 10)
						$display("sample_out mismatch at %0t: expected %0d, got %0d",
							$realtime, want, sample_out);
				end
			end
		end
	end

	function automatic filter_req_t sample_req(input int x, input int dry, input int lfo);
		filter_req_t r;
		r.func   = FUNC_PROCESS;
		r.sample = SAMPLE_W'(x);
		r.dry    = SAMPLE_W'(dry);
		r.lfo    = LFO_W'(lfo);
		r.slot   = SLOT_W'($urandom());
		r.word   = COEF_W'($urandom());
		return r;
	endfunction

	function automatic filter_req_t coef_req(input int slot, input int word);
		filter_req_t r;
		r.func   = FUNC_COEF;
		r.sample = SAMPLE_W'($urandom());
		r.dry    = SAMPLE_W'($urandom());
		r.lfo    = LFO_W'($urandom());
		r.slot   = SLOT_W'(slot);
		r.word   = COEF_W'(word);
		return r;
	endfunction

	function automatic filter_req_t random_req();
		int pick, x, lfo;
		pick = $urandom_range(99);
		if (pick < 10)
			return coef_req($urandom_range(31), $urandom());
		x = $urandom();
		if (pick < 14)
			x = SAMPLE_MAX;
		else if (pick < 18)
			x = SAMPLE_MIN;
		lfo = $urandom_range(65535);
		if ($urandom_range(9) == 0)
			lfo = $urandom_range(1) ? 65535 : 0;
		return sample_req(x, $urandom(), lfo);
	endfunction

	// leave in_valid high on return; the next request or wait_idle takes it over
	task automatic send_request(input filter_req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		func      <= r.func;
		sample_in <= r.sample;
		dry_in    <= r.dry;
		lfo_value <= r.lfo;
		coef_slot <= r.slot;
		coef_word <= r.word;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		requests_sent++;
		if (r.func == FUNC_COEF)
			coef_writes_sent++;
		apply_request(r);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_pace(input int idle, input int stall);
		send_idle_pct = idle;
		stall_pct = stall;
	endtask

	task automatic write_regs(input mode_t mode, input int base, input int dev, input int points);
		logic [CFG_DATA_W-1:0] value [4];
		cfg_idx_t              idx;
		wait_idle();
		value[CFG_MODE] = CFG_DATA_W'($urandom());
		value[CFG_MODE][MODE_W-1:0] = mode;
		value[CFG_BASE] = CFG_DATA_W'(base);
		value[CFG_DEV] = CFG_DATA_W'(dev);
		value[CFG_PCOUNT] = CFG_DATA_W'($urandom());
		value[CFG_PCOUNT][PCOUNT_W-1:0] = PCOUNT_W'(points);
		cfg_valid <= 1'b1;
		for (int i = 0; i < 4; i++) begin
			idx = cfg_idx_t'(i);
			cfg_index <= idx;
			cfg_data  <= value[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			case (idx)
				CFG_MODE:   cur_mode = mode_t'(value[i][MODE_W-1:0]);
				CFG_BASE:   cur_base = value[i];
				CFG_DEV:    cur_dev = value[i];
				CFG_PCOUNT: cur_points = value[i][PCOUNT_W-1:0];
			endcase
		end
		cfg_valid <= 1'b0;
		settings_count++;
	endtask

	function automatic int pick_delay();
		int r;
		r = $urandom_range(19);
		if (r < 14)
			return $urandom_range(31);
		if (r < 17)
			return $urandom_range(4095);
		return (r == 17) ? 0 : 4095;
	endfunction

	function automatic mode_t pick_mode();
		int r;
		r = $urandom_range(9);
		if (r < 4)
			return MODE_FF;
		if (r < 8)
			return MODE_FB;
		return (r == 8) ? MODE_MIX : MODE_BYPASS;
	endfunction

	task automatic test_coef_table();
		int w;
		for (int s = 0; s < 32; s++) begin
			w = $urandom();
			if (s == 0)
				w = 32767;
			else if (s == 1)
				w = -32768;
			else if (s == 2)
				w = 0;
			send_request(coef_req(s, w));
		end
	endtask

	task automatic test_bypass();
		send_request(sample_req(12345, SAMPLE_MAX, 0));
		send_request(sample_req(-1, SAMPLE_MIN, 65535));
	endtask

	task automatic test_mix();
		write_regs(MODE_MIX, 1, 0, 8);
		send_request(sample_req(SAMPLE_MAX, SAMPLE_MAX, 0));
		send_request(sample_req(SAMPLE_MIN, SAMPLE_MIN, 65535));
		send_request(sample_req(16384, -16384, 32768));
	endtask

	task automatic test_feedforward();
		write_regs(MODE_FF, 3, 5, 2);
		send_request(sample_req(SAMPLE_MAX, 0, 0));
		send_request(sample_req(SAMPLE_MIN, 0, 65535));
		send_request(sample_req(20000, 0, 40000));
		send_request(sample_req(-7, 0, 12));
		// zero delay: both taps land on the sample just stored
		write_regs(MODE_FF, 0, 0, 1);
		send_request(sample_req(SAMPLE_MAX, 0, 65535));
	endtask

	task automatic test_feedback();
		write_regs(MODE_FB, 2, 3, 4);
		for (int i = 0; i < 4; i++)
			send_request(sample_req($urandom(), 0, $urandom_range(65535)));
	endtask

	task automatic test_ring_limits();
		// clamped ring length, delay wrapping past it, point count above the table
		write_regs(MODE_FF, 4095, 4095, 15);
		send_request(sample_req(SAMPLE_MAX, 0, 65535));
		send_request(sample_req(SAMPLE_MIN, 0, 32767));
		// zero point count, then shrink the ring below the write position
		write_regs(MODE_FB, 40, 0, 0);
		for (int i = 0; i < 10; i++)
			send_request(sample_req($urandom(), 0, $urandom_range(65535)));
		write_regs(MODE_FF, 3, 0, 9);
		send_request(sample_req(1000, 0, 65535));
		send_request(sample_req(-1000, 0, 0));
	endtask

	task automatic test_random_traffic();
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg % 4)
				0: set_pace(0, 0);
				1: set_pace(84, 0);
				2: set_pace(0, 84);
				default: set_pace(9, 9);
			endcase
			write_regs(pick_mode(), pick_delay(), pick_delay(), $urandom_range(15));
			for (int n = 0; n < SEG_REQUESTS; n++)
				send_request(random_req());
		end
	endtask

	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		func       <= FUNC_PROCESS;
		sample_in  <= '0;
		dry_in     <= '0;
		lfo_value  <= '0;
		coef_slot  <= '0;
		coef_word  <= '0;
		cfg_valid  <= 1'b0;
		cfg_index  <= CFG_MODE;
		cfg_data   <= '0;
		cur_mode   = MODE_BYPASS;
		cur_base   = 1;
		cur_dev    = 0;
		cur_points = 1;
		write_pos  = 0;
		foreach (ring_mem[i])
			ring_mem[i] = '0;
		foreach (coef_mem[i])
			coef_mem[i] = '0;
		set_pace(0, 0);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_coef_table();
		test_bypass();
		test_mix();
		test_feedforward();
		test_feedback();
		test_ring_limits();
		test_random_traffic();
		wait_idle();

		$display("summary: %0d requests sent (%0d coefficient writes), %0d samples checked",
			requests_sent, coef_writes_sent, samples_checked);
		$display("summary: %0d register settings over four pacing patterns, %0d failures",
			settings_count, error_count);
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	initial begin
		#(8_000_000);
		$display("timeout with %0d samples still outstanding", expected_samples.size());
		$display("testbench: done, errors");
		$finish;
	end

endmodule

### files.f
+incdir+hdl
hdl/mdtf_pkg.sv
hdl/mdtf_ram.sv
hdl/mdtf_datapath.sv
hdl/mdtf_ctrl.sv
hdl/modulated_delay_tap_filter.sv
tb/sv/testbench.sv
